// ===== rtl/core/aesc_pkg.sv =====
// ----------------------------------------------------------------------------
// AES cipher package
// Shared constants, register indexes, S-box tables and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aesc_pkg;

    localparam int MAX_ROUNDS_DEF = 14;
    localparam int ROUNDS_128     = 10;
    localparam int ROUNDS_192     = 12;
    localparam int ROUNDS_256     = 14;

    typedef enum logic [2:0] {
        REG_KEY_SIZE   = 3'd0,
        REG_KEY_WORD_0 = 3'd1,
        REG_KEY_WORD_1 = 3'd2,
        REG_KEY_WORD_2 = 3'd3,
        REG_KEY_WORD_3 = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0,
        KEY_192 = 2'd1,
        KEY_256 = 2'd2,
        KEY_ALT = 2'd3
    } t_key_size;

    // Round key store write strobe and bank (even or odd half of a round key)
    typedef struct packed {
        logic we;
        logic bank;
    } t_kx_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'd99,8'd124,8'd119,8'd123,8'd242,8'd107,8'd111,8'd197,
        8'd48,8'd1,8'd103,8'd43,8'd254,8'd215,8'd171,8'd118,
        8'd202,8'd130,8'd201,8'd125,8'd250,8'd89,8'd71,8'd240,
        8'd173,8'd212,8'd162,8'd175,8'd156,8'd164,8'd114,8'd192,
        8'd183,8'd253,8'd147,8'd38,8'd54,8'd63,8'd247,8'd204,
        8'd52,8'd165,8'd229,8'd241,8'd113,8'd216,8'd49,8'd21,
        8'd4,8'd199,8'd35,8'd195,8'd24,8'd150,8'd5,8'd154,
        8'd7,8'd18,8'd128,8'd226,8'd235,8'd39,8'd178,8'd117,
        8'd9,8'd131,8'd44,8'd26,8'd27,8'd110,8'd90,8'd160,
        8'd82,8'd59,8'd214,8'd179,8'd41,8'd227,8'd47,8'd132,
        8'd83,8'd209,8'd0,8'd237,8'd32,8'd252,8'd177,8'd91,
        8'd106,8'd203,8'd190,8'd57,8'd74,8'd76,8'd88,8'd207,
        8'd208,8'd239,8'd170,8'd251,8'd67,8'd77,8'd51,8'd133,
        8'd69,8'd249,8'd2,8'd127,8'd80,8'd60,8'd159,8'd168,
        8'd81,8'd163,8'd64,8'd143,8'd146,8'd157,8'd56,8'd245,
        8'd188,8'd182,8'd218,8'd33,8'd16,8'd255,8'd243,8'd210,
        8'd205,8'd12,8'd19,8'd236,8'd95,8'd151,8'd68,8'd23,
        8'd196,8'd167,8'd126,8'd61,8'd100,8'd93,8'd25,8'd115,
        8'd96,8'd129,8'd79,8'd220,8'd34,8'd42,8'd144,8'd136,
        8'd70,8'd238,8'd184,8'd20,8'd222,8'd94,8'd11,8'd219,
        8'd224,8'd50,8'd58,8'd10,8'd73,8'd6,8'd36,8'd92,
        8'd194,8'd211,8'd172,8'd98,8'd145,8'd149,8'd228,8'd121,
        8'd231,8'd200,8'd55,8'd109,8'd141,8'd213,8'd78,8'd169,
        8'd108,8'd86,8'd244,8'd234,8'd101,8'd122,8'd174,8'd8,
        8'd186,8'd120,8'd37,8'd46,8'd28,8'd166,8'd180,8'd198,
        8'd232,8'd221,8'd116,8'd31,8'd75,8'd189,8'd139,8'd138,
        8'd112,8'd62,8'd181,8'd102,8'd72,8'd3,8'd246,8'd14,
        8'd97,8'd53,8'd87,8'd185,8'd134,8'd193,8'd29,8'd158,
        8'd225,8'd248,8'd152,8'd17,8'd105,8'd217,8'd142,8'd148,
        8'd155,8'd30,8'd135,8'd233,8'd206,8'd85,8'd40,8'd223,
        8'd140,8'd161,8'd137,8'd13,8'd191,8'd230,8'd66,8'd104,
        8'd65,8'd153,8'd45,8'd15,8'd176,8'd84,8'd187,8'd22
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
        8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
        8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
        8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
        8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
        8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
        8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
        8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
        8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
        8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
        8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
        8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
        8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
        8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
        8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
        8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
        8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] rounds_for(input logic [1:0] size);
        logic [7:0] nr;
        case (size)
            KEY_128: nr = 8'(ROUNDS_128);
            KEY_192: nr = 8'(ROUNDS_192);
            default: nr = 8'(ROUNDS_256);
        endcase
        return nr;
    endfunction

endpackage

// ===== rtl/core/aesc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module aesc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/aesc_keyexp.sv =====
// ----------------------------------------------------------------------------
// AES key expansion
// Produce one 32-bit schedule word a cycle; write a 64-bit entry per pair of words.
// ----------------------------------------------------------------------------
module aesc_keyexp #(
    parameter int MAX_ROUNDS = aesc_pkg::MAX_ROUNDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [1:0]                        i_key_size,
    input  logic [63:0]                       i_key_word [4],
    output logic                              o_busy,
    output logic [$clog2(MAX_ROUNDS+1)-1:0]   o_rounds,
    output aesc_pkg::t_kx_wr                  o_wr,
    output logic [$clog2(MAX_ROUNDS+1)-1:0]   o_waddr,
    output logic [63:0]                       o_wdata
);

    localparam int RW = $clog2(MAX_ROUNDS + 1);
    localparam int IW = $clog2(4 * (MAX_ROUNDS + 1));

    logic          r_busy, n_busy;
    logic [IW-1:0] r_idx, n_idx;
    logic [2:0]    r_km, n_km;
    logic [7:0]    r_rc, n_rc;
    logic [31:0]   r_win [8];
    logic [31:0]   n_win [8];

    logic [7:0]    need;
    logic [RW-1:0] nr;
    logic [3:0]    nk;
    logic [IW-1:0] last_idx;
    logic [31:0]   kw, tmp, wnew, wback;
    logic [63:0]   kword;

    always_comb begin
        need = aesc_pkg::rounds_for(i_key_size);
        nr   = (need > 8'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : need[RW-1:0];
        case (i_key_size)
            aesc_pkg::KEY_128: nk = 4'd4;
            aesc_pkg::KEY_192: nk = 4'd6;
            default:           nk = 4'd8;
        endcase
        last_idx = IW'({nr, 2'b11});
    end

    always_comb begin
        kword = i_key_word[r_idx[2:1]];
        kw    = r_idx[0] ? kword[31:0] : kword[63:32];
        wback = r_win[3'(nk - 4'd1)];
        tmp   = r_win[0];
        n_rc  = r_rc;
        if (r_km == 3'd0) begin
            tmp  = aesc_pkg::sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rc, 24'h0};
            n_rc = aesc_pkg::xtime(r_rc);
        end else if (nk == 4'd8 && r_km == 3'd4) begin
            tmp = aesc_pkg::sub_word(r_win[0]);
        end
        if (r_idx < IW'(nk)) begin
            wnew = kw;
            n_rc = r_rc;
        end else begin
            wnew = wback ^ tmp;
        end
    end

    always_comb begin
        n_win[0] = wnew;
        for (int k = 1; k < 8; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_busy = r_busy;
        n_idx  = r_idx;
        n_km   = r_km;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_km   = '0;
        end else if (r_busy) begin
            n_idx = r_idx + 1'b1;
            n_km  = (4'(r_km) == nk - 4'd1) ? 3'd0 : r_km + 3'd1;
            if (r_idx == last_idx) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_km   <= '0;
            r_rc   <= 8'h01;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_km   <= n_km;
            r_rc   <= i_start ? 8'h01 : (r_busy ? n_rc : r_rc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_win <= n_win;
        end
    end

    assign o_busy     = r_busy;
    assign o_rounds   = nr;
    assign o_wr.we    = r_busy & r_idx[0];
    assign o_wr.bank  = r_idx[1];
    assign o_waddr    = r_idx[IW-1:2];
    assign o_wdata    = {r_win[0], wnew};

endmodule

// ===== rtl/core/aesc_round.sv =====
// ----------------------------------------------------------------------------
// AES round
// One encryption or decryption round, or the initial key addition.
// ----------------------------------------------------------------------------
module aesc_round (
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  logic         i_mode,
    input  logic         i_first,
    input  logic         i_final,
    output logic [127:0] o_state
);

    logic [7:0] s  [16];
    logic [7:0] a  [16];
    logic [7:0] b  [16];
    logic [7:0] m  [16];
    logic [7:0] k  [16];
    logic [7:0] x1, x2, x4, x8;
    logic [7:0] c0, c1, c2, c3;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_state[127-8*i -: 8];
            k[i] = i_key[127-8*i -: 8];
        end
        // shift and substitute, byte 4c+r is row r of column c
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_mode) begin
                    a[4*c+r] = aesc_pkg::INV_SBOX[s[4*((c+4-r)%4)+r]];
                end else begin
                    a[4*c+r] = aesc_pkg::SBOX[s[4*((c+r)%4)+r]];
                end
            end
        end
        // decryption adds the key before the column mix
        for (int i = 0; i < 16; i++) begin
            b[i] = i_mode ? (a[i] ^ k[i]) : a[i];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                c0 = b[4*c+r];
                c1 = b[4*c+(r+1)%4];
                c2 = b[4*c+(r+2)%4];
                c3 = b[4*c+(r+3)%4];
                if (i_mode) begin
                    x1 = c0; x2 = aesc_pkg::xtime(x1); x4 = aesc_pkg::xtime(x2);
                    x8 = aesc_pkg::xtime(x4);
                    m[4*c+r] = x8 ^ x4 ^ x2;
                    x1 = c1; x2 = aesc_pkg::xtime(x1); x4 = aesc_pkg::xtime(x2);
                    x8 = aesc_pkg::xtime(x4);
                    m[4*c+r] = m[4*c+r] ^ x8 ^ x2 ^ x1;
                    x1 = c2; x2 = aesc_pkg::xtime(x1); x4 = aesc_pkg::xtime(x2);
                    x8 = aesc_pkg::xtime(x4);
                    m[4*c+r] = m[4*c+r] ^ x8 ^ x4 ^ x1;
                    x1 = c3; x2 = aesc_pkg::xtime(x1); x4 = aesc_pkg::xtime(x2);
                    x8 = aesc_pkg::xtime(x4);
                    m[4*c+r] = m[4*c+r] ^ x8 ^ x1;
                end else begin
                    x1 = c0; x2 = aesc_pkg::xtime(x1); x4 = x2; x8 = x2;
                    m[4*c+r] = x2;
                    x1 = c1; x2 = aesc_pkg::xtime(x1);
                    m[4*c+r] = m[4*c+r] ^ x2 ^ x1 ^ c2 ^ c3;
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (i_first) begin
                o_state[127-8*i -: 8] = s[i] ^ k[i];
            end else if (i_mode) begin
                o_state[127-8*i -: 8] = i_final ? b[i] : m[i];
            end else begin
                o_state[127-8*i -: 8] = (i_final ? b[i] : m[i]) ^ k[i];
            end
        end
    end

endmodule

// ===== rtl/core/aes_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES block cipher
// ECB encryption and decryption of 128-bit blocks with 128/192/256-bit keys.
// ----------------------------------------------------------------------------
// Each input transfer carries one block and a mode bit (0 encrypt, 1 decrypt)
// and yields exactly one result transfer. Round keys live in two RAMs (even
// and odd halves of each round key, MAX_ROUNDS+1 entries each). The initial
// key addition and the Nr rounds (10, 12 or 14) run one step per cycle, with
// each step's key read from the RAMs in the cycle before it; only the last
// round holds, while the output register is full and the output is stalled.
// Input is held off until the last round has written its result. A finished
// result waits in the output register without blocking the next item's
// rounds until it is complete. After reset and after every accepted key
// register write the key schedule produces 4*(Nr+1) words (44, 52 or 60),
// one schedule word a cycle; input and configuration are held off while it
// runs. Key size 3 acts as a 256-bit key; writes to indexes above 4 are
// dropped. Byte 0 of blocks and keys is the most significant byte.
// ----------------------------------------------------------------------------
module aes_block_cipher #(
    parameter int MAX_ROUNDS = aesc_pkg::MAX_ROUNDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int RW = $clog2(MAX_ROUNDS + 1);

    // key registers
    logic [1:0]   r_key_size;
    logic [63:0]  r_key_word [4];
    logic         cfg_xfer, kx_start;

    // key expansion
    logic              kx_busy;
    logic [RW-1:0]     nr;
    aesc_pkg::t_kx_wr  kx_wr;
    logic [RW-1:0]     kx_waddr;
    logic [63:0]       kx_wdata;

    // round datapath
    logic          r_run, n_run;
    logic [RW-1:0] r_step, n_step;
    logic          r_mode, n_mode;
    logic [127:0]  r_state;
    logic [127:0]  rnd_out;
    logic [RW-1:0] rd_addr;
    logic [63:0]   key_hi, key_lo;
    logic          in_xfer, last, advance;

    logic          r_out_valid;
    logic [127:0]  r_result;

    // ---- configuration ------------------------------------------------------
    assign o_cfg_ready = !kx_busy && !r_run;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        kx_start = 1'b0;
        if (cfg_xfer) begin
            unique case (i_cfg_index) inside
                aesc_pkg::REG_KEY_SIZE,
                aesc_pkg::REG_KEY_WORD_0,
                aesc_pkg::REG_KEY_WORD_1,
                aesc_pkg::REG_KEY_WORD_2,
                aesc_pkg::REG_KEY_WORD_3: kx_start = 1'b1;
                default:                  kx_start = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= '0;
            for (int i = 0; i < 4; i++) begin
                r_key_word[i] <= '0;
            end
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                aesc_pkg::REG_KEY_SIZE:   r_key_size    <= i_cfg_data[1:0];
                aesc_pkg::REG_KEY_WORD_0: r_key_word[0] <= i_cfg_data;
                aesc_pkg::REG_KEY_WORD_1: r_key_word[1] <= i_cfg_data;
                aesc_pkg::REG_KEY_WORD_2: r_key_word[2] <= i_cfg_data;
                aesc_pkg::REG_KEY_WORD_3: r_key_word[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aesc_keyexp #(.MAX_ROUNDS(MAX_ROUNDS)) u_keyexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (kx_start),
        .i_key_size (r_key_size),
        .i_key_word (r_key_word),
        .o_busy     (kx_busy),
        .o_rounds   (nr),
        .o_wr       (kx_wr),
        .o_waddr    (kx_waddr),
        .o_wdata    (kx_wdata)
    );

    // ---- round key store: u_ram_hi holds bytes 0..7, u_ram_lo bytes 8..15 ----
    aesc_ram #(.WIDTH(64), .DEPTH(MAX_ROUNDS + 1)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (kx_wr.we && !kx_wr.bank),
        .i_waddr (kx_waddr),
        .i_wdata (kx_wdata),
        .i_raddr (rd_addr),
        .o_rdata (key_hi)
    );

    aesc_ram #(.WIDTH(64), .DEPTH(MAX_ROUNDS + 1)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (kx_wr.we && kx_wr.bank),
        .i_waddr (kx_waddr),
        .i_wdata (kx_wdata),
        .i_raddr (rd_addr),
        .o_rdata (key_lo)
    );

    // ---- round sequencer ----------------------------------------------------
    assign o_in_stall = kx_busy || r_run;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign last       = (r_step == nr);
    // hold the last round while the output register is occupied and the output is stalled
    assign advance    = r_run && (!last || !r_out_valid || !i_out_stall);

    always_comb begin
        n_run  = r_run;
        n_step = r_step;
        n_mode = r_mode;
        if (in_xfer) begin
            n_run  = 1'b1;
            n_step = '0;
            n_mode = i_mode;
        end else if (advance) begin
            if (last) begin
                n_run = 1'b0;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
        // issue the key read for the next step in the cycle before its round
        rd_addr = n_mode ? (nr - n_step) : n_step;
    end

    aesc_round u_round (
        .i_state (r_state),
        .i_key   ({key_hi, key_lo}),
        .i_mode  (r_mode),
        .i_first (r_step == '0),
        .i_final (last),
        .o_state (rnd_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_step      <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_step <= n_step;
            r_mode <= n_mode;
            if (advance && last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_state <= {i_block_high, i_block_low};
        end else if (advance) begin
            r_state <= rnd_out;
        end
        if (advance && last) begin
            r_result <= rnd_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_high = r_result[127:64];
    assign o_result_low  = r_result[63:0];

    // ---- assertions ---------------------------------------------------------
    a_no_run_during_kx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kx_busy |-> !r_run)
        else $error("rounds running while key schedule busy");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_step <= nr))
        else $error("round step beyond round count");

    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_run))
        else $error("result appeared without a running item");

endmodule
